[design/fumg_pkg.sv]
// ----------------------------------------------------------------------------
// fumg_pkg
// Types and constants of the fisheye unwrap map generator.
// ----------------------------------------------------------------------------
package fumg_pkg;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
    } in_t;

    typedef struct packed {
        logic [18:0] source_u;
        logic [18:0] source_v;
        logic        u_clamped;
        logic        v_clamped;
    } out_t;

    typedef enum logic [2:0] {
        REG_FOCAL_X    = 3'd0,
        REG_FOCAL_Y    = 3'd1,
        REG_CENTER_X   = 3'd2,
        REG_CENTER_Y   = 3'd3,
        REG_DISTORTION = 3'd4,
        REG_THETA_STEP = 3'd5,
        REG_PHI_STEP   = 3'd6,
        REG_RIGHT_HALF = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [23:0] focal_x;
        logic [23:0] focal_y;
        logic [23:0] center_x;
        logic [23:0] center_y;
        logic [63:0] distortion_coefficients;
        logic [23:0] theta_step;
        logic [23:0] phi_step;
        logic        right_half;
    } cfg_t;

    // one queued job: reduced azimuth and saturated polar angle
    typedef struct packed {
        logic signed [27:0] az;
        logic        [26:0] phi;
    } job_t;

    localparam int FIFO_DEPTH = 4;
    localparam int TABLE_LEN  = 28;

    localparam logic [26:0]        ANGLE_MAX   = 27'd134217727;
    localparam logic signed [28:0] PI_Q24      = 29'sd52707179;
    localparam logic signed [28:0] TWO_PI_Q24  = 29'sd105414357;
    localparam logic signed [27:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [27:0] PI_Z        = 28'sd52707179;
    localparam logic signed [27:0] GAIN_Q24    = 28'sd10188014;
    localparam logic signed [40:0] ONE_Q24     = 41'sd16777216;
    localparam logic signed [40:0] POLY_LIM    = 41'sd4294967296;
    localparam logic signed [37:0] LIMIT_Q8    = 38'sd524032;

    localparam logic signed [27:0] ATAN_Q24 [TABLE_LEN] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069,
        28'sd65536,    28'sd32768,   28'sd16384,   28'sd8192,
        28'sd4096,     28'sd2048,    28'sd1024,    28'sd512,
        28'sd256,      28'sd128,     28'sd64,      28'sd32,
        28'sd16,       28'sd8,       28'sd4,       28'sd2,
        28'sd1,        28'sd0,       28'sd0,       28'sd0
    };

endpackage

[design/fisheye_unwrap_map_generator.sv]
// ----------------------------------------------------------------------------
// fisheye_unwrap_map_generator
// Fisheye polar unwrap map: map coordinate in, clamped source position out.
// ----------------------------------------------------------------------------
//   channel  ports                              beat
//   input    s_valid s_ready s_data             one map coordinate
//   result   m_valid m_ready m_data             one source position
//   config   cfg_valid cfg_ready cfg_index/data one register write
//
// One beat per cycle sustained while m_ready stays high. Path, in order:
// front product register, queue, CORDIC stages, then the polynomial and
// projection pipeline. Synchronous active-low reset clears control and
// loads configuration defaults, not datapath registers. A stalled result
// freezes the pipeline; the queue lets the front take beats until it fills.
module fisheye_unwrap_map_generator #(
    parameter int MAX_COLUMNS   = 4096,
    parameter int MAX_ROWS      = 4096,
    parameter int CORDIC_STAGES = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fumg_pkg::in_t      s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output fumg_pkg::out_t     m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  fumg_pkg::reg_idx_t cfg_index,
    input  logic [63:0]        cfg_data
);
    import fumg_pkg::*;

    cfg_t               cfg_reg;
    logic               adv;
    logic               q_full, q_empty, q_push;
    job_t               q_in, q_head;
    logic               c_valid, c_neg;
    logic signed [27:0] c_x, c_y;
    logic        [26:0] c_phi;

    assign cfg_ready = 1'b1;
    assign adv       = !m_valid || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focal_x  <= 24'd4194304;
            cfg_reg.focal_y  <= 24'd4194304;
            cfg_reg.center_x <= 24'd4194304;
            cfg_reg.center_y <= 24'd4194304;
            cfg_reg.distortion_coefficients <= '0;
            cfg_reg.theta_step <= '0;
            cfg_reg.phi_step   <= '0;
            cfg_reg.right_half <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FOCAL_X:    cfg_reg.focal_x  <= cfg_data[23:0];
                REG_FOCAL_Y:    cfg_reg.focal_y  <= cfg_data[23:0];
                REG_CENTER_X:   cfg_reg.center_x <= cfg_data[23:0];
                REG_CENTER_Y:   cfg_reg.center_y <= cfg_data[23:0];
                REG_DISTORTION: cfg_reg.distortion_coefficients <= cfg_data;
                REG_THETA_STEP: cfg_reg.theta_step <= cfg_data[23:0];
                REG_PHI_STEP:   cfg_reg.phi_step   <= cfg_data[23:0];
                REG_RIGHT_HALF: cfg_reg.right_half <= cfg_data[0];
                default: ;
            endcase
        end
    end

    fumg_front #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .cfg    (cfg_reg),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (q_in)
    );

    fumg_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_job(q_in),
        .full    (q_full),
        .pop     (adv && !q_empty),
        .empty   (q_empty),
        .head    (q_head)
    );

    fumg_cordic #(
        .STAGES(CORDIC_STAGES)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (!q_empty),
        .in_job   (q_head),
        .out_valid(c_valid),
        .out_x    (c_x),
        .out_y    (c_y),
        .out_neg  (c_neg),
        .out_phi  (c_phi)
    );

    fumg_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .cfg     (cfg_reg),
        .in_valid(c_valid),
        .in_x    (c_x),
        .in_y    (c_y),
        .in_neg  (c_neg),
        .in_phi  (c_phi),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

    a_u_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.u_clamped |->
            (m_data.source_u == '0) || (m_data.source_u == LIMIT_Q8[18:0]))
        else $error("u clamp flag without limit value");

    a_v_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.v_clamped |->
            (m_data.source_v == '0) || (m_data.source_v == LIMIT_Q8[18:0]))
        else $error("v clamp flag without limit value");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_push)
        else $error("push into full queue");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

[design/fumg_front.sv]
// ----------------------------------------------------------------------------
// fumg_front
// Accepts map coordinates, forms azimuth and polar angle, queues the job.
// ----------------------------------------------------------------------------
module fumg_front #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  fumg_pkg::in_t s_data,
    input  fumg_pkg::cfg_t cfg,
    input  logic          q_full,
    output logic          q_push,
    output fumg_pkg::job_t q_job
);
    import fumg_pkg::*;

    logic        vld_reg;
    logic [35:0] az_prod_reg, phi_prod_reg;
    logic [11:0] col_c, row_c;
    logic [26:0] az_sat, phi_sat;
    logic signed [28:0] az_a, az_b;

    assign col_c = (s_data.column > 12'(MAX_COLUMNS - 1)) ? 12'(MAX_COLUMNS - 1) : s_data.column;
    assign row_c = (s_data.row > 12'(MAX_ROWS - 1)) ? 12'(MAX_ROWS - 1) : s_data.row;

    assign q_push  = vld_reg && !q_full;
    assign s_ready = !vld_reg || !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (q_push) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            az_prod_reg  <= col_c * cfg.theta_step;
            phi_prod_reg <= row_c * cfg.phi_step;
        end
    end

    always_comb begin
        az_sat  = (az_prod_reg > 36'(ANGLE_MAX)) ? ANGLE_MAX : az_prod_reg[26:0];
        phi_sat = (phi_prod_reg > 36'(ANGLE_MAX)) ? ANGLE_MAX : phi_prod_reg[26:0];
        az_a    = $signed({2'b00, az_sat}) - (cfg.right_half ? PI_Q24 : 29'sd0);
        az_b    = (az_a > PI_Q24) ? az_a - TWO_PI_Q24 : az_a;
        q_job.az  = az_b[27:0];
        q_job.phi = phi_sat;
    end

endmodule

[design/fumg_fifo.sv]
// ----------------------------------------------------------------------------
// fumg_fifo
// Short job queue between the front and the compute pipeline.
// ----------------------------------------------------------------------------
module fumg_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  fumg_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           empty,
    output fumg_pkg::job_t head
);
    import fumg_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    job_t            mem [FIFO_DEPTH];
    logic [PW-1:0]   wr_reg, rd_reg;
    logic [PW:0]     cnt_reg;

    assign full  = (cnt_reg == (PW+1)'(FIFO_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop)  rd_reg <= rd_reg + 1'b1;
            if (push && !pop) cnt_reg <= cnt_reg + 1'b1;
            else if (pop && !push) cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_job;
        end
    end

endmodule

[design/fumg_cordic.sv]
// ----------------------------------------------------------------------------
// fumg_cordic
// Pipelined rotation CORDIC for cosine and sine of the azimuth.
// ----------------------------------------------------------------------------
module fumg_cordic #(
    parameter int STAGES = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  fumg_pkg::job_t     in_job,
    output logic               out_valid,
    output logic signed [27:0] out_x,
    output logic signed [27:0] out_y,
    output logic               out_neg,
    output logic        [26:0] out_phi
);
    import fumg_pkg::*;

    logic               v_reg   [STAGES+1];
    logic signed [27:0] x_reg   [STAGES+1];
    logic signed [27:0] y_reg   [STAGES+1];
    logic signed [27:0] z_reg   [STAGES+1];
    logic               neg_reg [STAGES+1];
    logic        [26:0] phi_reg [STAGES+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg[0]   <= GAIN_Q24;
            y_reg[0]   <= '0;
            phi_reg[0] <= in_job.phi;
            if (in_job.az > HALF_PI_Q24) begin
                z_reg[0]   <= in_job.az - PI_Z;
                neg_reg[0] <= 1'b1;
            end else if (in_job.az < -HALF_PI_Q24) begin
                z_reg[0]   <= in_job.az + PI_Z;
                neg_reg[0] <= 1'b1;
            end else begin
                z_reg[0]   <= in_job.az;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g+1] <= 1'b0;
            end else if (adv) begin
                v_reg[g+1] <= v_reg[g];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                neg_reg[g+1] <= neg_reg[g];
                phi_reg[g+1] <= phi_reg[g];
                if (!z_reg[g][27]) begin
                    x_reg[g+1] <= x_reg[g] - (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] + (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] - ATAN_Q24[g];
                end else begin
                    x_reg[g+1] <= x_reg[g] + (y_reg[g] >>> g);
                    y_reg[g+1] <= y_reg[g] - (x_reg[g] >>> g);
                    z_reg[g+1] <= z_reg[g] + ATAN_Q24[g];
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign out_x     = x_reg[STAGES];
    assign out_y     = y_reg[STAGES];
    assign out_neg   = neg_reg[STAGES];
    assign out_phi   = phi_reg[STAGES];

endmodule

[design/fumg_back.sv]
// ----------------------------------------------------------------------------
// fumg_back
// Distortion polynomial, radius and projection to clamped pixel position.
// ----------------------------------------------------------------------------
module fumg_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  fumg_pkg::cfg_t     cfg,
    input  logic               in_valid,
    input  logic signed [27:0] in_x,
    input  logic signed [27:0] in_y,
    input  logic               in_neg,
    input  logic        [26:0] in_phi,
    output logic               m_valid,
    output fumg_pkg::out_t     m_data
);
    import fumg_pkg::*;

    function automatic logic signed [39:0] rnd24(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v + 64'sd8388608;
        return s[63:24];
    endfunction

    function automatic logic signed [40:0] coef(input logic [63:0] k, input int n);
        logic signed [15:0] raw;
        raw = k[16*n +: 16];
        return 41'(raw) <<< 10;
    endfunction

    function automatic logic signed [33:0] sat(input logic signed [40:0] v);
        if (v > POLY_LIM) return POLY_LIM[33:0];
        if (v < -POLY_LIM) return -POLY_LIM[33:0];
        return v[33:0];
    endfunction

    logic               v_reg   [15];
    logic        [53:0] pp_reg;
    logic        [26:0] phi_reg [10];
    logic signed [27:0] cv_reg  [12];
    logic signed [27:0] sv_reg  [12];
    logic        [30:0] p_reg   [1:7];
    logic signed [33:0] acc_reg [5];
    logic signed [63:0] m_reg   [4];
    logic signed [63:0] m10_reg, mu_reg, mv_reg, pu_reg, pv_reg;
    logic signed [36:0] rad_reg;
    logic signed [39:0] rtu_reg, rtv_reg;

    logic        [53:0] pp_w;
    logic signed [65:0] mh_w [4];
    logic signed [40:0] hs_w [4];
    logic signed [40:0] ct_w [4];
    logic signed [61:0] m10_w;
    logic signed [39:0] rad_w;
    logic signed [64:0] mu_w, mv_w;
    logic signed [64:0] pu_w, pv_w;
    logic signed [65:0] su_w, sv_w;
    logic signed [37:0] qu_w, qv_w;
    out_t               res_w;

    always_comb begin
        pp_w  = in_phi * in_phi;
        ct_w[0] = coef(cfg.distortion_coefficients, 2);
        ct_w[1] = coef(cfg.distortion_coefficients, 1);
        ct_w[2] = coef(cfg.distortion_coefficients, 0);
        ct_w[3] = ONE_Q24;
        for (int j = 0; j < 4; j++) begin
            mh_w[j] = $signed({1'b0, p_reg[1+2*j]}) * acc_reg[j];
            hs_w[j] = ct_w[j] + 41'(rnd24(m_reg[j]));
        end
        m10_w = $signed({1'b0, phi_reg[9]}) * acc_reg[4];
        rad_w = rnd24(m10_reg);
        mu_w  = rad_reg * cv_reg[11];
        mv_w  = rad_reg * sv_reg[11];
        pu_w  = $signed({1'b0, cfg.focal_x}) * rtu_reg;
        pv_w  = $signed({1'b0, cfg.focal_y}) * rtv_reg;
        su_w  = 66'(pu_reg) + $signed({18'b0, cfg.center_x, 24'b0}) + 66'sd134217728;
        sv_w  = 66'(pv_reg) + $signed({18'b0, cfg.center_y, 24'b0}) + 66'sd134217728;
        qu_w  = su_w[65:28];
        qv_w  = sv_w[65:28];
        if (qu_w < 0) begin
            res_w.source_u = '0;
            res_w.u_clamped = 1'b1;
        end else if (qu_w > LIMIT_Q8) begin
            res_w.source_u = LIMIT_Q8[18:0];
            res_w.u_clamped = 1'b1;
        end else begin
            res_w.source_u = qu_w[18:0];
            res_w.u_clamped = 1'b0;
        end
        if (qv_w < 0) begin
            res_w.source_v = '0;
            res_w.v_clamped = 1'b1;
        end else if (qv_w > LIMIT_Q8) begin
            res_w.source_v = LIMIT_Q8[18:0];
            res_w.v_clamped = 1'b1;
        end else begin
            res_w.source_v = qv_w[18:0];
            res_w.v_clamped = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 15; k++) v_reg[k] <= 1'b0;
            m_valid <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k < 15; k++) v_reg[k] <= v_reg[k-1];
            m_valid <= v_reg[14];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pp_reg     <= pp_w;
            phi_reg[0] <= in_phi;
            cv_reg[0]  <= in_neg ? -in_x : in_x;
            sv_reg[0]  <= in_neg ? -in_y : in_y;
            for (int k = 1; k < 10; k++) phi_reg[k] <= phi_reg[k-1];
            for (int k = 1; k < 12; k++) begin
                cv_reg[k] <= cv_reg[k-1];
                sv_reg[k] <= sv_reg[k-1];
            end
            p_reg[1]   <= 31'((pp_reg + 54'd8388608) >> 24);
            for (int k = 2; k < 8; k++) p_reg[k] <= p_reg[k-1];
            acc_reg[0] <= sat(coef(cfg.distortion_coefficients, 3));
            for (int j = 0; j < 4; j++) begin
                m_reg[j]     <= mh_w[j][63:0];
                acc_reg[j+1] <= sat(hs_w[j]);
            end
            m10_reg <= 64'(m10_w);
            rad_reg <= rad_w[36:0];
            mu_reg  <= mu_w[63:0];
            mv_reg  <= mv_w[63:0];
            rtu_reg <= rnd24(mu_reg);
            rtv_reg <= rnd24(mv_reg);
            pu_reg  <= pu_w[63:0];
            pv_reg  <= pv_w[63:0];
            m_data  <= res_w;
        end
    end

endmodule
